// ----- rtl/psd_pkg.sv -----
// Package for the point to segment distance unit.
// Holds widths, the case code type and the transaction structs.
// No dependencies.
`default_nettype none
package psd_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int SumW   = ProdW + 1;
  localparam int HalfW  = DiffW;
  localparam int MagW   = 2 * HalfW;
  localparam int SqW    = 2 * MagW;
  localparam int FracW  = 16;
  localparam int NumW   = SqW + FracW;
  localparam int DenW   = MagW;
  localparam int DistW  = 25;
  localparam int QuoW   = 2 * DistW;
  localparam int SrW    = QuoW + 2;
  localparam logic [DistW-1:0] DistMax = '1;

  typedef enum logic [1:0] {
    CASE_DEGEN = 2'd0,
    CASE_END1  = 2'd1,
    CASE_END2  = 2'd2,
    CASE_PERP  = 2'd3
  } case_t;

  typedef struct packed {
    logic signed [CoordW-1:0] end1_x;
    logic signed [CoordW-1:0] end1_y;
    logic signed [CoordW-1:0] end2_x;
    logic signed [CoordW-1:0] end2_y;
    logic signed [CoordW-1:0] probe_x;
    logic signed [CoordW-1:0] probe_y;
  } in_item_t;

  typedef struct packed {
    logic [DistW-1:0] distance_q8;
    case_t            nearest_case;
  } out_item_t;

  // Work handed from the front to the back: find floor(sqrt(num / den)).
  typedef struct packed {
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
    case_t           kind;
  } work_t;

endpackage
`default_nettype wire

// ----- rtl/psd_front.sv -----
// Front part: differences, products, case selection and the squared numerator.
// Depends on psd_pkg.
`default_nettype none
module psd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire psd_pkg::in_item_t item,
  input  wire logic             adv,
  output logic                  work_valid,
  output psd_pkg::work_t        work
);

  localparam int DiffW = psd_pkg::DiffW;
  localparam int ProdW = psd_pkg::ProdW;
  localparam int SumW  = psd_pkg::SumW;
  localparam int HalfW = psd_pkg::HalfW;
  localparam int MagW  = psd_pkg::MagW;
  localparam int SqW   = psd_pkg::SqW;
  localparam int DenW  = psd_pkg::DenW;

  logic [6:1] valid_r;

  // Stage 1: coordinate differences.
  logic signed [DiffW-1:0] ldx_r, ldy_r, o1x_r, o1y_r, o2x_r, o2y_r;
  // Stage 2: products.
  logic signed [ProdW-1:0] d1a_r, d1b_r, d2a_r, d2b_r, cra_r, crb_r;
  logic signed [ProdW-1:0] lxx_r, lyy_r, a1x_r, a1y_r, a2x_r, a2y_r;
  logic                    ldz_r;
  // Stage 3: sums.
  logic signed [SumW-1:0]  dot1_r, dot2_r, cross_r, den3_r, s1_r, s2_r;
  logic                    ldz3_r;
  // Stage 4: classification.
  psd_pkg::case_t          kind4_r;
  logic [MagW-1:0]         pt4_r, den4_r;
  logic [HalfW-1:0]        hi4_r, lo4_r;
  // Stage 5: partial products of the cross product square.
  psd_pkg::case_t          kind5_r;
  logic [MagW-1:0]         pt5_r, den5_r, hh5_r, hl5_r, ll5_r;
  // Stage 6: work item.
  psd_pkg::work_t          work6_r;

  logic signed [SumW-1:0]  cross_mag;
  psd_pkg::case_t          kind_nxt;
  logic [MagW-1:0]         pt_nxt;
  logic [SqW-1:0]          sq_nxt;

  // Valid bits move together under one advance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[5:1], load};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ldx_r <= DiffW'(item.end2_x) - DiffW'(item.end1_x);
      ldy_r <= DiffW'(item.end2_y) - DiffW'(item.end1_y);
      o1x_r <= DiffW'(item.probe_x) - DiffW'(item.end1_x);
      o1y_r <= DiffW'(item.probe_y) - DiffW'(item.end1_y);
      o2x_r <= DiffW'(item.probe_x) - DiffW'(item.end2_x);
      o2y_r <= DiffW'(item.probe_y) - DiffW'(item.end2_y);

      d1a_r <= ldx_r * o1x_r;
      d1b_r <= ldy_r * o1y_r;
      d2a_r <= ldx_r * o2x_r;
      d2b_r <= ldy_r * o2y_r;
      cra_r <= ldx_r * o1y_r;
      crb_r <= ldy_r * o1x_r;
      lxx_r <= ldx_r * ldx_r;
      lyy_r <= ldy_r * ldy_r;
      a1x_r <= o1x_r * o1x_r;
      a1y_r <= o1y_r * o1y_r;
      a2x_r <= o2x_r * o2x_r;
      a2y_r <= o2y_r * o2y_r;
      ldz_r <= (ldx_r == '0) && (ldy_r == '0);

      dot1_r  <= SumW'(d1a_r) + SumW'(d1b_r);
      dot2_r  <= SumW'(d2a_r) + SumW'(d2b_r);
      cross_r <= SumW'(cra_r) - SumW'(crb_r);
      den3_r  <= SumW'(lxx_r) + SumW'(lyy_r);
      s1_r    <= SumW'(a1x_r) + SumW'(a1y_r);
      s2_r    <= SumW'(a2x_r) + SumW'(a2y_r);
      ldz3_r  <= ldz_r;

      kind4_r <= kind_nxt;
      pt4_r   <= pt_nxt;
      den4_r  <= MagW'(den3_r);
      hi4_r   <= cross_mag[MagW-1:HalfW];
      lo4_r   <= cross_mag[HalfW-1:0];

      kind5_r <= kind4_r;
      pt5_r   <= pt4_r;
      den5_r  <= den4_r;
      hh5_r   <= hi4_r * hi4_r;
      hl5_r   <= hi4_r * lo4_r;
      ll5_r   <= lo4_r * lo4_r;

      work6_r.kind <= kind5_r;
      work6_r.num  <= {sq_nxt, {psd_pkg::FracW{1'b0}}};
      work6_r.den  <= (kind5_r == psd_pkg::CASE_PERP) ? den5_r : DenW'(1);
    end
  end

  // Case selection: end1 is tested before end2, a zero dot product is not behind.
  always_comb begin
    cross_mag = cross_r[SumW-1] ? -cross_r : cross_r;
    priority if (ldz3_r) begin
      kind_nxt = psd_pkg::CASE_DEGEN;
      pt_nxt   = MagW'(s1_r);
    end else if (dot1_r[SumW-1]) begin
      kind_nxt = psd_pkg::CASE_END1;
      pt_nxt   = MagW'(s1_r);
    end else if (!dot2_r[SumW-1] && (dot2_r != '0)) begin
      kind_nxt = psd_pkg::CASE_END2;
      pt_nxt   = MagW'(s2_r);
    end else begin
      kind_nxt = psd_pkg::CASE_PERP;
      pt_nxt   = '0;
    end
  end

  // Square of the cross product from its halves, or the point distance square.
  always_comb begin
    if (kind5_r == psd_pkg::CASE_PERP) begin
      sq_nxt = (SqW'(hh5_r) << (2 * HalfW)) + (SqW'(hl5_r) << (HalfW + 1)) + SqW'(ll5_r);
    end else begin
      sq_nxt = SqW'(pt5_r);
    end
  end

  assign work_valid = valid_r[6];
  assign work       = work6_r;

endmodule
`default_nettype wire

// ----- rtl/psd_fifo.sv -----
// Short queue of work transactions between the front and the back.
// Depends on psd_pkg.
`default_nettype none
module psd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire psd_pkg::work_t push_data,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output psd_pkg::work_t      head
);

  localparam int Depth = 4;
  localparam int AddrW = $clog2(Depth);

  psd_pkg::work_t   mem [Depth];
  logic [AddrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AddrW:0]   count_r;

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  assign full  = (count_r == (AddrW+1)'(Depth));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

endmodule
`default_nettype wire

// ----- rtl/psd_back.sv -----
// Back part: pipelined restoring division, pipelined square root, result register.
// Depends on psd_pkg.
`default_nettype none
module psd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fifo_empty,
  input  wire psd_pkg::work_t   fifo_head,
  output logic                  fifo_pop,
  input  wire logic             out_pop,
  output logic                  out_empty,
  output psd_pkg::out_item_t    out_data
);

  localparam int NumW  = psd_pkg::NumW;
  localparam int DenW  = psd_pkg::DenW;
  localparam int QuoW  = psd_pkg::QuoW;
  localparam int DistW = psd_pkg::DistW;
  localparam int SrW   = psd_pkg::SrW;

  logic adv;

  // Division stages.
  logic [QuoW:0]      d_valid_r;
  logic [NumW-1:0]    d_rem_r  [QuoW+1];
  logic [DenW-1:0]    d_den_r  [QuoW+1];
  logic [QuoW-1:0]    d_quo_r  [QuoW+1];
  logic [QuoW:0]      d_sat_r;
  psd_pkg::case_t     d_kind_r [QuoW+1];

  // Square root stages.
  logic [DistW:0]     s_valid_r;
  logic [SrW-1:0]     s_rem_r  [DistW+1];
  logic [DistW-1:0]   s_q_r    [DistW+1];
  logic [DistW:0]     s_sat_r;
  psd_pkg::case_t     s_kind_r [DistW+1];

  logic               out_valid_r;
  psd_pkg::out_item_t out_r;
  logic               sat_in;

  assign adv      = !out_valid_r || out_pop;
  assign fifo_pop = adv && !fifo_empty;
  // A quotient of more than 2*DistW bits would give a distance beyond the output range.
  assign sat_in   = ({{QuoW{1'b0}}, fifo_head.num} >=
                     ({{NumW{1'b0}}, fifo_head.den} << QuoW));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r   <= '0;
      s_valid_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      d_valid_r   <= {d_valid_r[QuoW-1:0], !fifo_empty};
      s_valid_r   <= {s_valid_r[DistW-1:0], d_valid_r[QuoW]};
      out_valid_r <= s_valid_r[DistW];
    end
  end

  // Division entry.
  always_ff @(posedge clk) begin
    if (adv) begin
      d_rem_r[0]  <= fifo_head.num;
      d_den_r[0]  <= fifo_head.den;
      d_quo_r[0]  <= '0;
      d_sat_r[0]  <= sat_in;
      d_kind_r[0] <= fifo_head.kind;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < QuoW; k++) begin : g_div
    localparam int B = QuoW - 1 - k;
    logic [NumW-1:0] trial;
    logic            take;
    assign trial = NumW'({{NumW{1'b0}}, d_den_r[k]} << B);
    assign take  = (d_rem_r[k] >= trial);
    always_ff @(posedge clk) begin
      if (adv) begin
        d_rem_r[k+1]  <= take ? (d_rem_r[k] - trial) : d_rem_r[k];
        d_quo_r[k+1]  <= d_quo_r[k] | (QuoW'(take) << B);
        d_den_r[k+1]  <= d_den_r[k];
        d_sat_r[k+1]  <= d_sat_r[k];
        d_kind_r[k+1] <= d_kind_r[k];
      end
    end
  end

  // Square root entry.
  always_ff @(posedge clk) begin
    if (adv) begin
      s_rem_r[0]  <= SrW'(d_quo_r[QuoW]);
      s_q_r[0]    <= '0;
      s_sat_r[0]  <= d_sat_r[QuoW];
      s_kind_r[0] <= d_kind_r[QuoW];
    end
  end

  // One root bit per stage: (q + 2^b)^2 - q^2 = q*2^(b+1) + 2^(2b).
  for (genvar j = 0; j < DistW; j++) begin : g_sqrt
    localparam int B = DistW - 1 - j;
    logic [SrW-1:0] trial;
    logic           take;
    assign trial = (SrW'(s_q_r[j]) << (B + 1)) + (SrW'(1) << (2 * B));
    assign take  = (s_rem_r[j] >= trial);
    always_ff @(posedge clk) begin
      if (adv) begin
        s_rem_r[j+1]  <= take ? (s_rem_r[j] - trial) : s_rem_r[j];
        s_q_r[j+1]    <= s_q_r[j] | (DistW'(take) << B);
        s_sat_r[j+1]  <= s_sat_r[j];
        s_kind_r[j+1] <= s_kind_r[j];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.distance_q8  <= s_sat_r[DistW] ? psd_pkg::DistMax : s_q_r[DistW];
      out_r.nearest_case <= s_kind_r[DistW];
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ----- rtl/point_to_segment_distance_unit.sv -----
// Path from push to result: 6 front stages, queue, 51 division stages, 26 square
// root stages, result register. One transaction per cycle through the fully
// pipelined division and root, unless the result side stalls and holds the path.
// Reset: synchronous, active low; it empties the pipelines, the queue and the result.
// Top level of the point to segment distance unit; depends on psd_pkg, psd_front,
// psd_fifo and psd_back.
`default_nettype none
module point_to_segment_distance_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire psd_pkg::in_item_t  in_data,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output psd_pkg::out_item_t      out_data
);

  logic           front_adv;
  logic           work_valid;
  psd_pkg::work_t work;
  logic           q_full, q_empty, q_pop;
  psd_pkg::work_t q_head;

  // The front moves unless its last stage holds work the queue cannot take.
  assign front_adv = !work_valid || !q_full || q_pop;
  assign in_full   = !front_adv;

  psd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_push),
    .item       (in_data),
    .adv        (front_adv),
    .work_valid (work_valid),
    .work       (work)
  );

  psd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_adv && work_valid),
    .push_data (work),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  psd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (q_empty),
    .fifo_head  (q_head),
    .fifo_pop   (q_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
